FILE: rtl/core/crt_pkg.sv
// Package for the chunk retrieval tracker: field widths, operation and action
// codes, controller states and the structs shared by the core modules.
// No dependencies.
`default_nettype none

package crt_pkg;

  // Fixed field widths.
  localparam int OP_W     = 3;
  localparam int VER_W    = 10;
  localparam int CLASS_W  = 16;
  localparam int CHUNK_W  = 12;
  localparam int MCOUNT_W = 16;
  localparam int ACT_W    = 3;
  localparam int ICC_W    = 13;

  // Wide enough for any bit index or count up to the largest bitmap size.
  localparam int IDX_X_W = 17;

  // Default bitmap geometry. The word width must be a power of two.
  localparam int MAP_BITS_DEF      = 4096;
  localparam int MAP_WORD_BITS_DEF = 32;

  // Reset value of the initial chunk count register.
  localparam logic [ICC_W-1:0] ICC_RESET = 13'd1000;

  // Configuration port.
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  localparam logic [1:0] REG_GATEWAY_MODE = 2'd0;
  localparam logic [1:0] REG_CASCADE_MODE = 2'd1;
  localparam logic [1:0] REG_OWN_CLASS    = 2'd2;
  localparam logic [1:0] REG_INIT_COUNT   = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_MANIFEST_DATA = 3'd0,
    OP_CHUNK_DATA    = 3'd1,
    OP_CHUNK_REQ     = 3'd2,
    OP_MANIFEST_REQ  = 3'd3,
    OP_CACHE_QUERY   = 3'd4,
    OP_RETRY_TICK    = 3'd5
  } op_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_PASS         = 3'd0,
    ACT_REQ_MANIFEST = 3'd1,
    ACT_REQ_CHUNK    = 3'd2,
    ACT_SERVE        = 3'd3,
    ACT_CONSUME      = 3'd4,
    ACT_CACHE        = 3'd5,
    ACT_NO_CACHE     = 3'd6
  } act_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LAST_RD,
    S_EVAL,
    S_SET_WR,
    S_SCAN,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic                gateway_mode;
    logic                cascade_mode;
    logic [CLASS_W-1:0]  own_class;
    logic [ICC_W-1:0]    initial_chunk_count;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic [ICC_W-1:0] value;
  } cnt_load_t;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [VER_W-1:0]    item_version;
    logic [CLASS_W-1:0]  item_class;
    logic [CHUNK_W-1:0]  item_chunk;
    logic [MCOUNT_W-1:0] manifest_count;
    logic                from_local;
  } item_t;

  typedef struct packed {
    act_t               action;
    logic [VER_W-1:0]   out_version;
    logic [CHUNK_W-1:0] out_chunk;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic adopt;
    logic rd_chunk;
    logic rd_last;
    logic cap_chunk_bit;
    logic wr_set;
    logic scan_init;
    logic scan_step;
    logic set_res;
    act_t res_act;
    logic push;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic gw;
    logic cascade;
    logic from_local;
    logic ver_gt;
    logic ver_eq;
    logic ver_lt;
    logic ver_gt_next;
    logic cls_eq;
    logic cur_none;
    logic in_range;
    logic rd_bit;
    logic chunk_held;
    logic count_zero;
    logic scan_found;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/crt_if.sv
// Handshake interfaces for the tracker's item and result channels.
// Depends on crt_pkg for the field widths and the action type.
`default_nettype none

interface crt_item_if import crt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [VER_W-1:0]    item_version;
  logic [CLASS_W-1:0]  item_class;
  logic [CHUNK_W-1:0]  item_chunk;
  logic [MCOUNT_W-1:0] manifest_count;
  logic                from_local;

  modport source (
    output valid, operation, item_version, item_class, item_chunk,
    output manifest_count, from_local,
    input  ready
  );
  modport sink (
    input  valid, operation, item_version, item_class, item_chunk,
    input  manifest_count, from_local,
    output ready
  );
endinterface

interface crt_result_if import crt_pkg::*; ();
  logic               valid;
  logic               ready;
  act_t               action;
  logic [VER_W-1:0]   out_version;
  logic [CHUNK_W-1:0] out_chunk;

  modport source (output valid, action, out_version, out_chunk, input ready);
  modport sink (input valid, action, out_version, out_chunk, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/crt_regs.sv
// Configuration registers of the tracker behind an APB-style port.
// Depends on crt_pkg for the register map and the cfg_t struct.
`default_nettype none

module crt_regs import crt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg,
  output cnt_load_t         cnt_load
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gateway_mode        <= 1'b0;
      cfg.cascade_mode        <= 1'b0;
      cfg.own_class           <= '0;
      cfg.initial_chunk_count <= ICC_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_GATEWAY_MODE: cfg.gateway_mode        <= pwdata[0];
        REG_CASCADE_MODE: cfg.cascade_mode        <= pwdata[0];
        REG_OWN_CLASS:    cfg.own_class           <= pwdata[CLASS_W-1:0];
        REG_INIT_COUNT:   cfg.initial_chunk_count <= pwdata[ICC_W-1:0];
      endcase
    end
  end

  // Writing the initial count also reloads the working chunk count.
  assign cnt_load.load  = wr && (idx == REG_INIT_COUNT);
  assign cnt_load.value = pwdata[ICC_W-1:0];

  always_comb begin
    unique case (idx)
      REG_GATEWAY_MODE: prdata = APB_DW'(cfg.gateway_mode);
      REG_CASCADE_MODE: prdata = APB_DW'(cfg.cascade_mode);
      REG_OWN_CLASS:    prdata = APB_DW'(cfg.own_class);
      REG_INIT_COUNT:   prdata = APB_DW'(cfg.initial_chunk_count);
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/crt_ctrl.sv
// Controller of the tracker: a state machine that sequences lookups, the
// read-modify-write of a bitmap word and the missing-chunk scan.
// Depends on crt_pkg for states, commands and status.
`default_nettype none

module crt_ctrl import crt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  accept,
  output logic  ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // Decisions taken in the decode state.
  state_t dec_next;
  act_t   dec_act;
  logic   dec_adopt;
  logic   dec_rd;
  logic   dec_scan;

  act_t   eval_act;
  logic   scan_done;
  act_t   scan_act;

  always_comb begin
    dec_next  = S_RESULT;
    dec_act   = ACT_PASS;
    dec_adopt = 1'b0;
    dec_rd    = 1'b0;
    dec_scan  = 1'b0;
    unique case (stat.op)
      OP_MANIFEST_DATA: begin
        if (!stat.gw && stat.ver_gt) begin
          dec_adopt = 1'b1;
          dec_scan  = 1'b1;
          dec_next  = S_SCAN;
        end
      end
      OP_CHUNK_DATA: begin
        if (!stat.gw && stat.ver_eq && stat.cls_eq) begin
          if (stat.in_range) begin
            dec_rd   = 1'b1;
            dec_next = S_SET_WR;
          end else begin
            dec_scan = 1'b1;
            dec_next = S_SCAN;
          end
        end
      end
      OP_CHUNK_REQ: begin
        priority if (stat.from_local) begin
          dec_act = ACT_PASS;
        end else if (!stat.gw && stat.ver_gt) begin
          dec_act = ACT_REQ_MANIFEST;
        end else if (!stat.gw && stat.ver_lt) begin
          dec_act = ACT_CONSUME;
        end else begin
          dec_rd   = 1'b1;
          dec_next = S_LAST_RD;
        end
      end
      OP_MANIFEST_REQ: begin
        if (!stat.gw && !stat.from_local && stat.ver_gt_next) begin
          dec_act = ACT_REQ_MANIFEST;
        end
      end
      OP_CACHE_QUERY: begin
        dec_rd   = 1'b1;
        dec_next = S_EVAL;
      end
      OP_RETRY_TICK: begin
        priority if (stat.gw) begin
          dec_act = ACT_PASS;
        end else if (stat.cur_none) begin
          dec_act = ACT_REQ_MANIFEST;
        end else begin
          dec_scan = 1'b1;
          dec_next = S_SCAN;
        end
      end
      default: dec_act = ACT_PASS;
    endcase
  end

  // In the evaluate state the read data holds the chunk bit for a cache
  // query, or the last chunk's bit for a chunk request.
  always_comb begin
    if (stat.op == OP_CACHE_QUERY) begin
      if (!stat.gw && stat.ver_eq && stat.cls_eq && stat.rd_bit) begin
        eval_act = ACT_NO_CACHE;
      end else begin
        eval_act = ACT_CACHE;
      end
    end else begin
      priority if (stat.cascade && !(stat.count_zero || stat.rd_bit)) begin
        eval_act = ACT_CONSUME;
      end else if (stat.chunk_held && (stat.gw || stat.cls_eq)) begin
        eval_act = ACT_SERVE;
      end else begin
        eval_act = ACT_PASS;
      end
    end
  end

  assign scan_done = stat.count_zero || stat.scan_found || stat.scan_last;
  assign scan_act  = (!stat.count_zero && stat.scan_found) ? ACT_REQ_CHUNK : ACT_PASS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (accept) state_next = S_DECODE;
      S_DECODE:  state_next = dec_next;
      S_LAST_RD: state_next = S_EVAL;
      S_EVAL:    state_next = S_RESULT;
      S_SET_WR:  state_next = S_SCAN;
      S_SCAN:    if (scan_done) state_next = S_RESULT;
      S_RESULT:  if (stat.out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd   = '0;
    ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        ready       = 1'b1;
        cmd.capture = accept;
      end
      S_DECODE: begin
        cmd.adopt     = dec_adopt;
        cmd.rd_chunk  = dec_rd;
        cmd.scan_init = dec_scan;
        cmd.set_res   = (dec_next == S_RESULT);
        cmd.res_act   = dec_act;
      end
      S_LAST_RD: begin
        cmd.cap_chunk_bit = 1'b1;
        cmd.rd_last       = 1'b1;
      end
      S_EVAL: begin
        cmd.set_res = 1'b1;
        cmd.res_act = eval_act;
      end
      S_SET_WR: begin
        cmd.wr_set    = 1'b1;
        cmd.scan_init = 1'b1;
      end
      S_SCAN: begin
        cmd.set_res   = scan_done;
        cmd.res_act   = scan_act;
        cmd.scan_step = !scan_done;
      end
      S_RESULT: begin
        cmd.push = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/crt_dpath.sv
// Datapath of the tracker: item register, version and count, the bitmap
// memory with per-word valid bits, the scan counters and the result registers.
// Depends on crt_pkg for the item, result, command and status structs.
`default_nettype none

module crt_dpath import crt_pkg::*; #(
  parameter int MAP_BITS      = MAP_BITS_DEF,
  parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  item_t     item_in,
  input  cfg_t      cfg,
  input  cnt_load_t cnt_load,
  input  cmd_t      cmd,
  output stat_t     stat,
  output logic      res_valid,
  input  logic      res_ready,
  output res_t      res
);

  localparam int WORDS   = (MAP_BITS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int WB_W    = $clog2(MAP_WORD_BITS);
  localparam int CNT_W   = $clog2(MAP_BITS + 1);
  localparam int XW      = IDX_X_W;
  localparam logic [XW-1:0] MAP_LIMIT = XW'(MAP_BITS);
  localparam logic [CNT_W-1:0] CNT_RESET =
    (XW'(ICC_RESET) > MAP_LIMIT) ? CNT_W'(MAP_BITS) : CNT_W'(ICC_RESET);

  item_t              itm;
  logic               cur_none;
  logic [VER_W-1:0]   cur_ver;
  logic [CNT_W-1:0]   count;

  logic [MAP_WORD_BITS-1:0] map_mem [WORDS];
  logic [WORDS-1:0]         valid;
  logic [MAP_WORD_BITS-1:0] mem_q;
  logic                     valid_q;
  logic [WB_W-1:0]          bitpos_q;
  logic                     rd_ok_q;
  logic [MAP_WORD_BITS-1:0] eff_q;
  logic [MAP_WORD_BITS-1:0] wdata;
  logic                     chunk_held;

  logic                     rd_en;
  logic [WADDR_W-1:0]       raddr;
  logic [WB_W-1:0]          rbit;
  logic                     rok;

  logic [XW-1:0]      chunk_x;
  logic               in_range;
  logic [WADDR_W-1:0] chunk_word;
  logic [WB_W-1:0]    chunk_bit;
  logic [XW-1:0]      cm1;
  logic [WADDR_W-1:0] last_word;
  logic [WB_W-1:0]    last_rem;

  logic [WADDR_W-1:0]       rd_idx;
  logic [WADDR_W-1:0]       chk_idx;
  logic                     chk_valid;
  logic [MAP_WORD_BITS-1:0] mask;
  logic [MAP_WORD_BITS-1:0] missing;
  logic [WB_W-1:0]          first;
  logic [XW-1:0]            found_x;

  act_t               res_act_p;
  logic [VER_W-1:0]   res_ver_p;
  logic [CHUNK_W-1:0] res_chunk_p;
  logic [VER_W-1:0]   ver_p;
  logic [CHUNK_W-1:0] chunk_p;
  logic [XW-1:0]      mcount_x;
  logic [XW-1:0]      icc_x;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      itm <= item_in;
    end
  end

  // Item geometry.
  assign chunk_x    = XW'(itm.item_chunk);
  assign in_range   = chunk_x < MAP_LIMIT;
  assign chunk_word = WADDR_W'(chunk_x >> WB_W);
  assign chunk_bit  = WB_W'(chunk_x);
  assign cm1        = XW'(count) - XW'(1);
  assign last_word  = WADDR_W'(cm1 >> WB_W);
  assign last_rem   = WB_W'(cm1);
  assign mcount_x   = XW'(itm.manifest_count);
  assign icc_x      = XW'(cnt_load.value);

  // Version and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_none <= 1'b1;
      cur_ver  <= '0;
      count    <= CNT_RESET;
    end else if (cmd.adopt) begin
      cur_none <= 1'b0;
      cur_ver  <= itm.item_version;
      count    <= (mcount_x > MAP_LIMIT) ? CNT_W'(MAP_BITS) : CNT_W'(mcount_x);
    end else if (cnt_load.load) begin
      count    <= (icc_x > MAP_LIMIT) ? CNT_W'(MAP_BITS) : CNT_W'(icc_x);
    end
  end

  // Single read port of the bitmap memory.
  always_comb begin
    rd_en = 1'b1;
    raddr = '0;
    rbit  = '0;
    rok   = 1'b1;
    priority if (cmd.rd_chunk) begin
      raddr = in_range ? chunk_word : '0;
      rbit  = chunk_bit;
      rok   = in_range;
    end else if (cmd.rd_last) begin
      raddr = last_word;
      rbit  = last_rem;
    end else if (cmd.scan_step) begin
      raddr = rd_idx;
    end else begin
      rd_en = 1'b0;
    end
  end

  assign eff_q = valid_q ? mem_q : '0;
  assign wdata = eff_q | (MAP_WORD_BITS'(1) << bitpos_q);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q    <= map_mem[raddr];
      valid_q  <= valid[raddr];
      bitpos_q <= rbit;
      rd_ok_q  <= rok;
    end
    if (cmd.wr_set) begin
      map_mem[chunk_word] <= wdata;
    end
  end

  // A word that is not valid reads as all zero, so a new manifest clears the
  // whole bitmap by clearing only the valid bits.
  always_ff @(posedge clk) begin
    if (rst || cmd.adopt) begin
      valid <= '0;
    end else if (cmd.wr_set) begin
      valid[chunk_word] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_chunk_bit) begin
      chunk_held <= stat.rd_bit;
    end
  end

  // Scan: one word read per cycle, checked in the cycle after.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      chk_valid <= 1'b0;
    end else begin
      chk_valid <= cmd.scan_step;
      if (cmd.scan_init) begin
        rd_idx <= '0;
      end else if (cmd.scan_step && (rd_idx != last_word)) begin
        rd_idx <= rd_idx + WADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      chk_idx <= rd_idx;
    end
  end

  always_comb begin
    for (int j = 0; j < MAP_WORD_BITS; j++) begin
      mask[j] = (chk_idx != last_word) || (WB_W'(j) <= last_rem);
    end
  end

  assign missing = ~eff_q & mask;

  always_comb begin
    first = '0;
    for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
      if (missing[j]) begin
        first = WB_W'(j);
      end
    end
  end

  assign found_x = (XW'(chk_idx) << WB_W) | XW'(first);

  // Status.
  always_comb begin
    stat.op          = op_t'(itm.operation);
    stat.gw          = cfg.gateway_mode;
    stat.cascade     = cfg.cascade_mode;
    stat.from_local  = itm.from_local;
    stat.ver_gt      = cur_none || (itm.item_version > cur_ver);
    stat.ver_eq      = !cur_none && (itm.item_version == cur_ver);
    stat.ver_lt      = !cur_none && (itm.item_version < cur_ver);
    stat.ver_gt_next = cur_none ? (itm.item_version != '0)
                                : ({1'b0, itm.item_version} > ({1'b0, cur_ver} + 11'd1));
    stat.cls_eq      = itm.item_class == cfg.own_class;
    stat.cur_none    = cur_none;
    stat.in_range    = in_range;
    stat.rd_bit      = cfg.gateway_mode || (rd_ok_q && eff_q[bitpos_q]);
    stat.chunk_held  = chunk_held;
    stat.count_zero  = count == '0;
    stat.scan_found  = chk_valid && (|missing);
    stat.scan_last   = chk_valid && (chk_idx == last_word);
    stat.out_free    = !res_valid || res_ready;
  end

  // Result fields follow from the action.
  always_comb begin
    ver_p   = '0;
    chunk_p = '0;
    unique case (cmd.res_act)
      ACT_REQ_MANIFEST: ver_p = cur_none ? '0 : (cur_ver + VER_W'(1));
      ACT_REQ_CHUNK: begin
        ver_p   = cur_ver;
        chunk_p = CHUNK_W'(found_x);
      end
      ACT_SERVE: begin
        ver_p   = cfg.gateway_mode ? '0 : cur_ver;
        chunk_p = itm.item_chunk;
      end
      default: begin
        ver_p   = '0;
        chunk_p = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_act_p   <= cmd.res_act;
      res_ver_p   <= ver_p;
      res_chunk_p <= chunk_p;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.push) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      res.action      <= res_act_p;
      res.out_version <= res_ver_p;
      res.out_chunk   <= res_chunk_p;
    end
  end

`ifndef SYNTH
  // A new manifest leaves no word of the bitmap marked as written.
  a_adopt_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.adopt |=> (valid == '0))
    else $error("bitmap not cleared after manifest adoption");

  // A missing chunk found by the scan always lies below the chunk count.
  a_found_in_count: assert property (@(posedge clk) disable iff (rst)
    stat.scan_found |-> (found_x < XW'(count)))
    else $error("scan found a chunk beyond the chunk count");

  // A result is moved to the output register only when the slot is free.
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!res_valid || res_ready))
    else $error("result pushed over an untaken beat");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/chunk_retrieval_tracker_top.sv
// Top level of the chunk retrieval tracker: configuration registers,
// controller and datapath. Depends on crt_pkg, crt_if, crt_regs, crt_ctrl, crt_dpath.
`default_nettype none

// The tracker takes one firmware-update event per item beat and returns one
// result beat for each. It keeps the version being retrieved, a chunk count
// and a bitmap of held chunks in a single-port memory of MAP_BITS/MAP_WORD_BITS
// words. Items are handled one at a time: an item is taken only while the
// controller is idle, and the result sits in an output register, so the next
// item is taken while a result still waits. A request, query or mismatching
// item goes from decode, via the read and evaluate states for a bitmap lookup,
// to the result state and is pushed once the output register is free. An item
// that ends in a search for the first missing chunk (an adopted manifest, a
// matching chunk, a retry tick) scans the bitmap, one word per cycle through
// the memory's one read port. Each word carries a valid flag, so a new manifest
// clears the bitmap with no pass over memory. The user must write configuration
// through the APB port only while no item is in flight; the block does not
// enforce this. Writing the initial chunk count also reloads the working count.

module chunk_retrieval_tracker_top import crt_pkg::*; #(
  parameter int MAP_BITS      = MAP_BITS_DEF,
  parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  crt_item_if.sink          item,
  crt_result_if.source      result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t      cfg;
  cnt_load_t cnt_load;
  cmd_t      cmd;
  stat_t     stat;
  item_t     item_in;
  res_t      res;
  logic      res_valid;
  logic      ready;
  logic      accept;

  // An item beat is taken when the controller is idle.
  assign item.ready = ready;
  assign accept     = item.valid && ready;

  assign item_in.operation      = item.operation;
  assign item_in.item_version   = item.item_version;
  assign item_in.item_class     = item.item_class;
  assign item_in.item_chunk     = item.item_chunk;
  assign item_in.manifest_count = item.manifest_count;
  assign item_in.from_local     = item.from_local;

  assign result.valid       = res_valid;
  assign result.action      = res.action;
  assign result.out_version = res.out_version;
  assign result.out_chunk   = res.out_chunk;

  crt_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .cnt_load (cnt_load)
  );

  crt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .ready  (ready),
    .stat   (stat),
    .cmd    (cmd)
  );

  crt_dpath #(
    .MAP_BITS      (MAP_BITS),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .item_in   (item_in),
    .cfg       (cfg),
    .cnt_load  (cnt_load),
    .cmd       (cmd),
    .stat      (stat),
    .res_valid (res_valid),
    .res_ready (result.ready),
    .res       (res)
  );

endmodule

`default_nettype wire

FILE: bench/crt_tracker_checker.sv
// Scoreboard for the chunk retrieval tracker: watches the event, result and
// configuration ports, predicts each result and compares it. Uses crt_pkg and crt_if.
`timescale 1ns / 1ps

module crt_tracker_checker import crt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  crt_item_if               item_mon,
  crt_result_if             result_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                fail_count,
  output int                pending,
  output int                events_seen,
  output int                results_seen
);

  localparam int MAP_SIZE = MAP_BITS_DEF;

  // Shadow of the configuration registers.
  logic               gw_cfg;
  logic               cascade_cfg;
  logic [CLASS_W-1:0] class_cfg;
  logic [ICC_W-1:0]   icc_cfg;

  // Shadow of the tracker state; a version of -1 means none adopted yet.
  int                cur_ver;
  int                chunk_total;
  bit [MAP_SIZE-1:0] held_map;

  res_t expected_q[$];
  int   mismatches;
  int   n_events;
  int   n_results;

  function automatic int clamp_count(int n);
    return (n > MAP_SIZE) ? MAP_SIZE : n;
  endfunction

  function automatic bit is_held(int idx);
    if (gw_cfg) return 1'b1;
    if (idx >= MAP_SIZE) return 1'b0;
    return held_map[idx];
  endfunction

  function automatic res_t make_res(act_t a, int v, int c);
    res_t r;
    r.action      = a;
    r.out_version = VER_W'(v);
    r.out_chunk   = CHUNK_W'(c);
    return r;
  endfunction

  function automatic res_t first_missing();
    for (int i = 0; i < chunk_total; i++) begin
      if (!is_held(i)) return make_res(ACT_REQ_CHUNK, cur_ver, i);
    end
    return make_res(ACT_PASS, 0, 0);
  endfunction

  function automatic res_t predict_event(item_t ev);
    res_t r;
    int   ver;
    int   chunk;
    bit   last_held;
    r     = make_res(ACT_PASS, 0, 0);
    ver   = int'(ev.item_version);
    chunk = int'(ev.item_chunk);
    case (ev.operation)
      OP_MANIFEST_DATA: begin
        if (!gw_cfg && ver > cur_ver) begin
          cur_ver     = ver;
          chunk_total = clamp_count(int'(ev.manifest_count));
          held_map    = '0;
          r           = first_missing();
        end
      end
      OP_CHUNK_DATA: begin
        if (!gw_cfg && ver == cur_ver && ev.item_class == class_cfg) begin
          if (chunk < MAP_SIZE) held_map[chunk] = 1'b1;
          r = first_missing();
        end
      end
      OP_CHUNK_REQ: begin
        if (!ev.from_local) begin
          if (!gw_cfg && ver > cur_ver) begin
            r = make_res(ACT_REQ_MANIFEST, cur_ver + 1, 0);
          end else if (!gw_cfg && ver < cur_ver) begin
            r = make_res(ACT_CONSUME, 0, 0);
          end else begin
            last_held = (chunk_total == 0) || is_held(chunk_total - 1);
            if (cascade_cfg && !last_held) begin
              r = make_res(ACT_CONSUME, 0, 0);
            end else if (is_held(chunk) && (gw_cfg || ev.item_class == class_cfg)) begin
              r = make_res(ACT_SERVE, gw_cfg ? 0 : cur_ver, chunk);
            end
          end
        end
      end
      OP_MANIFEST_REQ: begin
        if (!gw_cfg && !ev.from_local && ver > cur_ver + 1) begin
          r = make_res(ACT_REQ_MANIFEST, cur_ver + 1, 0);
        end
      end
      OP_CACHE_QUERY: begin
        if (!gw_cfg && ver == cur_ver && ev.item_class == class_cfg && is_held(chunk)) begin
          r = make_res(ACT_NO_CACHE, 0, 0);
        end else begin
          r = make_res(ACT_CACHE, 0, 0);
        end
      end
      OP_RETRY_TICK: begin
        if (!gw_cfg) begin
          if (cur_ver < 0) r = make_res(ACT_REQ_MANIFEST, cur_ver + 1, 0);
          else r = first_missing();
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    item_t ev;
    res_t  exp_r;
    if (rst) begin
      gw_cfg      = 1'b0;
      cascade_cfg = 1'b0;
      class_cfg   = '0;
      icc_cfg     = ICC_RESET;
      cur_ver     = -1;
      chunk_total = clamp_count(int'(ICC_RESET));
      held_map    = '0;
      expected_q.delete();
      mismatches  = 0;
      n_events    = 0;
      n_results   = 0;
    end else begin
      // Results are retired before new events are predicted, so a beat
      // always meets the expectation of an earlier event.
      if (result_mon.valid && result_mon.ready) begin
        n_results++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result beat with nothing expected: action %0d version %0d chunk %0d",
                     $realtime, result_mon.action, result_mon.out_version,
                     result_mon.out_chunk);
        end else begin
          exp_r = expected_q.pop_front();
          if (result_mon.action !== exp_r.action ||
              result_mon.out_version !== exp_r.out_version ||
              result_mon.out_chunk !== exp_r.out_chunk) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] result %0d: expected action %0d version %0d chunk %0d, got %0d %0d %0d",
                       $realtime, n_results, exp_r.action, exp_r.out_version,
                       exp_r.out_chunk, result_mon.action, result_mon.out_version,
                       result_mon.out_chunk);
          end
        end
      end

      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_GATEWAY_MODE: gw_cfg = pwdata[0];
          REG_CASCADE_MODE: cascade_cfg = pwdata[0];
          REG_OWN_CLASS:    class_cfg = pwdata[CLASS_W-1:0];
          REG_INIT_COUNT: begin
            icc_cfg     = pwdata[ICC_W-1:0];
            chunk_total = clamp_count(int'(icc_cfg));
          end
          default: ;
        endcase
      end

      if (item_mon.valid && item_mon.ready) begin
        ev.operation      = item_mon.operation;
        ev.item_version   = item_mon.item_version;
        ev.item_class     = item_mon.item_class;
        ev.item_chunk     = item_mon.item_chunk;
        ev.manifest_count = item_mon.manifest_count;
        ev.from_local     = item_mon.from_local;
        expected_q.push_back(predict_event(ev));
        n_events++;
      end
    end
    pending      <= expected_q.size();
    fail_count   <= mismatches;
    events_seen  <= n_events;
    results_seen <= n_results;
  end

endmodule

FILE: bench/chunk_retrieval_tracker_top_tb.sv
// Testbench top for the chunk retrieval tracker: clock, reset, event stimulus,
// result back-pressure and APB setup. Uses crt_pkg, crt_if and crt_tracker_checker.
`timescale 1ns / 1ps

module chunk_retrieval_tracker_top_tb import crt_pkg::*; ();

  // Operation codes that the block must pass on untouched.
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

  localparam logic [CLASS_W-1:0] HOME_CLASS  = 16'hA55A;
  localparam logic [CLASS_W-1:0] OTHER_CLASS = 16'h5AA5;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending;
  int events_seen;
  int results_seen;

  // Stimulus bookkeeping: what the sender believes the block is retrieving,
  // so that most random events form well-formed update sequences.
  int                 stim_ver;
  int                 stim_count;
  int                 fill_idx;
  logic [CLASS_W-1:0] stim_class;
  bit                 stim_gw;
  // Set for the closing stretch, where neither side idles.
  bit                 quiet;

  crt_item_if   item_bus ();
  crt_result_if result_bus ();

  chunk_retrieval_tracker_top uut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_bus),
    .result  (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  crt_tracker_checker scoreboard (
    .clk          (clk),
    .rst          (rst),
    .item_mon     (item_bus),
    .result_mon   (result_bus),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .events_seen  (events_seen),
    .results_seen (results_seen)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Hard stop in case the block hangs. The slowest correct run stays below
  // a fifth of this.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result back-pressure: ready drops for random bursts, with long stretches of
  // steady acceptance in between. Every branch makes at most one assignment to
  // ready per clock edge.
  initial begin
    result_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 7) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // One APB write: a setup cycle, an access cycle, then a cycle with the
  // port released so that back-to-back writes never retoggle psel in a step.
  task automatic cfg_write(logic [1:0] idx, logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one event beat and returns at the edge that accepts it. Valid is
  // left high so the next beat can follow without a bubble; an idle burst
  // lowers it first.
  task automatic send_item(item_t ev);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    item_bus.valid          <= 1'b1;
    item_bus.operation      <= ev.operation;
    item_bus.item_version   <= ev.item_version;
    item_bus.item_class     <= ev.item_class;
    item_bus.item_chunk     <= ev.item_chunk;
    item_bus.manifest_count <= ev.manifest_count;
    item_bus.from_local     <= ev.from_local;
    do @(posedge clk); while (!item_bus.ready);
  endtask

  task automatic send_event(logic [OP_W-1:0] op, int ver, logic [CLASS_W-1:0] cls,
                            int chunk, int mcount, bit from_loop);
    item_t ev;
    ev.operation      = op;
    ev.item_version   = VER_W'(ver);
    ev.item_class     = cls;
    ev.item_chunk     = CHUNK_W'(chunk);
    ev.manifest_count = MCOUNT_W'(mcount);
    ev.from_local     = from_loop;
    send_item(ev);
  endtask

  // Stops offering events and waits until every result has come back; the
  // extra wait after that covers the output register and the checker's lag.
  task automatic drain();
    item_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  // Mostly well-formed traffic around the version being retrieved: new
  // manifests, chunk data filled in order, requests and queries against the
  // current version, and a share of fully random noise.
  task automatic send_random();
    item_t ev;
    int    pick;
    int    v;
    int    top_chunk;
    ev        = '0;
    pick      = $urandom_range(0, 99);
    v         = (stim_ver < 0) ? 0 : stim_ver;
    top_chunk = (stim_count > 0) ? stim_count - 1 : 0;
    if (pick < 5 && stim_ver < 990) begin
      ev.operation    = OP_MANIFEST_DATA;
      ev.item_version = VER_W'(v + $urandom_range(1, 3));
      case ($urandom_range(0, 9))
        0: ev.manifest_count = MCOUNT_W'($urandom_range(4097, 65535));
        1: ev.manifest_count = MCOUNT_W'($urandom_range(13, 300));
        default: ev.manifest_count = MCOUNT_W'($urandom_range(1, 12));
      endcase
      // In gateway mode the block ignores manifests, so nothing changes.
      if (!stim_gw) begin
        stim_ver   = int'(ev.item_version);
        stim_count = (ev.manifest_count > 4096) ? 4096 : int'(ev.manifest_count);
        fill_idx   = 0;
      end
    end else if (pick < 40) begin
      ev.operation    = OP_CHUNK_DATA;
      ev.item_version = VER_W'(v);
      ev.item_class   = ($urandom_range(0, 9) == 0) ? CLASS_W'($urandom) : stim_class;
      if ($urandom_range(0, 9) < 7 && fill_idx < stim_count) begin
        ev.item_chunk = CHUNK_W'(fill_idx);
        fill_idx++;
      end else if ($urandom_range(0, 11) == 0) begin
        ev.item_chunk = CHUNK_W'($urandom);
      end else begin
        ev.item_chunk = CHUNK_W'($urandom_range(0, top_chunk));
      end
    end else if (pick < 55) begin
      ev.operation = OP_CHUNK_REQ;
      case ($urandom_range(0, 7))
        0: ev.item_version = VER_W'((v < 999) ? v + 1 : v);
        1: ev.item_version = VER_W'((v > 0) ? v - 1 : 0);
        default: ev.item_version = VER_W'(v);
      endcase
      ev.item_class = ($urandom_range(0, 7) == 0) ? CLASS_W'($urandom) : stim_class;
      ev.item_chunk = CHUNK_W'($urandom_range(0, stim_count));
      ev.from_local = ($urandom_range(0, 7) == 0);
    end else if (pick < 63) begin
      ev.operation    = OP_MANIFEST_REQ;
      ev.item_version = VER_W'((v + 3 > 999) ? 999 : v + $urandom_range(0, 3));
      ev.from_local   = ($urandom_range(0, 5) == 0);
    end else if (pick < 75) begin
      ev.operation    = OP_CACHE_QUERY;
      ev.item_version = ($urandom_range(0, 4) == 0) ? VER_W'($urandom_range(0, 999))
                                                    : VER_W'(v);
      ev.item_class   = ($urandom_range(0, 5) == 0) ? CLASS_W'($urandom) : stim_class;
      ev.item_chunk   = CHUNK_W'($urandom_range(0, top_chunk));
    end else if (pick < 85) begin
      ev.operation = OP_RETRY_TICK;
    end else begin
      ev.operation      = OP_W'($urandom_range(0, 7));
      ev.item_version   = VER_W'($urandom_range(0, 999));
      ev.item_class     = CLASS_W'($urandom);
      ev.item_chunk     = CHUNK_W'($urandom);
      ev.manifest_count = MCOUNT_W'($urandom);
      ev.from_local     = 1'($urandom);
      // Noise must not adopt a version, or the version range runs out early.
      if (ev.operation == OP_MANIFEST_DATA) ev.item_version = VER_W'($urandom_range(0, v));
    end
    send_item(ev);
  endtask

  task automatic run_random(int n, int quiet_from);
    for (int i = 0; i < n; i++) begin
      if (i == quiet_from) quiet = 1'b1;
      send_random();
    end
  endtask

  initial begin
    // Every input of the block is known from time zero.
    rst                     <= 1'b1;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    item_bus.valid          <= 1'b0;
    item_bus.operation      <= '0;
    item_bus.item_version   <= '0;
    item_bus.item_class     <= '0;
    item_bus.item_chunk     <= '0;
    item_bus.manifest_count <= '0;
    item_bus.from_local     <= 1'b0;
    quiet      = 1'b0;
    stim_gw    = 1'b0;
    stim_ver   = -1;
    stim_count = 8;
    fill_idx   = 0;
    stim_class = HOME_CLASS;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Plain node, a small count until the first manifest arrives.
    cfg_write(REG_GATEWAY_MODE, 32'd0);
    cfg_write(REG_CASCADE_MODE, 32'd0);
    cfg_write(REG_OWN_CLASS, 32'(HOME_CLASS));
    cfg_write(REG_INIT_COUNT, 32'd8);

    // Directed walk. Before any manifest, retries and requests ask for
    // version 0.
    send_event(OP_RETRY_TICK, 0, 16'h0000, 0, 0, 1'b0);
    send_event(OP_CHUNK_REQ, 0, HOME_CLASS, 0, 0, 1'b0);
    send_event(OP_MANIFEST_REQ, 5, 16'h0000, 0, 0, 1'b0);
    send_event(OP_CACHE_QUERY, 0, HOME_CLASS, 0, 0, 1'b0);
    // Unknown operations with every field but the version at its top value, then at zero.
    send_event(OP_UNUSED_6, 999, 16'hFFFF, 4095, 65535, 1'b1);
    send_event(OP_UNUSED_7, 0, 16'h0000, 0, 0, 1'b0);
    // Adopt version 3 with four chunks and fill it, with a foreign-class
    // chunk and a chunk far past the count on the way.
    send_event(OP_MANIFEST_DATA, 3, 16'h0000, 0, 4, 1'b0);
    send_event(OP_CHUNK_DATA, 3, HOME_CLASS, 0, 0, 1'b0);
    send_event(OP_CHUNK_DATA, 3, OTHER_CLASS, 1, 0, 1'b0);
    send_event(OP_CHUNK_DATA, 3, HOME_CLASS, 4095, 0, 1'b0);
    send_event(OP_CHUNK_DATA, 3, HOME_CLASS, 3, 0, 1'b0);
    send_event(OP_CACHE_QUERY, 3, HOME_CLASS, 0, 0, 1'b0);
    send_event(OP_CHUNK_REQ, 3, HOME_CLASS, 0, 0, 1'b0);
    send_event(OP_CHUNK_REQ, 3, HOME_CLASS, 0, 0, 1'b1);
    send_event(OP_CHUNK_REQ, 2, HOME_CLASS, 0, 0, 1'b0);
    send_event(OP_CHUNK_REQ, 9, HOME_CLASS, 0, 0, 1'b0);
    // A manifest request only counts when it skips past the next version.
    send_event(OP_MANIFEST_REQ, 4, 16'h0000, 0, 0, 1'b0);
    send_event(OP_MANIFEST_REQ, 5, 16'h0000, 0, 0, 1'b0);
    send_event(OP_CHUNK_DATA, 3, HOME_CLASS, 1, 0, 1'b0);
    send_event(OP_CHUNK_DATA, 3, HOME_CLASS, 2, 0, 1'b0);
    send_event(OP_RETRY_TICK, 0, 16'h0000, 0, 0, 1'b0);
    // Stale manifest, then a manifest with no chunks at all.
    send_event(OP_MANIFEST_DATA, 3, 16'h0000, 0, 9, 1'b0);
    send_event(OP_MANIFEST_DATA, 4, 16'h0000, 0, 0, 1'b0);
    send_event(OP_CHUNK_REQ, 4, HOME_CLASS, 0, 0, 1'b0);
    send_event(OP_RETRY_TICK, 0, 16'h0000, 0, 0, 1'b0);
    // A manifest count above the bitmap size is clamped.
    send_event(OP_MANIFEST_DATA, 5, 16'h0000, 0, 65535, 1'b0);
    stim_ver   = 5;
    stim_count = 4096;
    drain();

    // Cascade node with a random class; reloading the count shrinks the
    // current retrieval to five chunks.
    stim_class = CLASS_W'($urandom);
    cfg_write(REG_CASCADE_MODE, 32'd1);
    cfg_write(REG_OWN_CLASS, 32'(stim_class));
    cfg_write(REG_INIT_COUNT, 32'd5);
    stim_count = 5;
    run_random(140, 141);
    drain();

    // Gateway: every chunk is held and the state is frozen.
    cfg_write(REG_GATEWAY_MODE, 32'd1);
    stim_gw = 1'b1;
    run_random(80, 81);
    drain();

    // Plain node again, top class value and a zero count.
    stim_gw    = 1'b0;
    stim_class = 16'hFFFF;
    cfg_write(REG_GATEWAY_MODE, 32'd0);
    cfg_write(REG_CASCADE_MODE, 32'd0);
    cfg_write(REG_OWN_CLASS, 32'(stim_class));
    cfg_write(REG_INIT_COUNT, 32'd0);
    stim_count = 0;
    send_event(OP_RETRY_TICK, 0, 16'h0000, 0, 0, 1'b0);
    run_random(140, 141);
    drain();

    // Largest count register value, clamped to the whole bitmap, then version
    // 999. The closing stretch runs without idling.
    stim_class = 16'h0000;
    cfg_write(REG_CASCADE_MODE, 32'd1);
    cfg_write(REG_OWN_CLASS, 32'(stim_class));
    cfg_write(REG_INIT_COUNT, 32'd8191);
    stim_count = 4096;
    send_event(OP_RETRY_TICK, 0, 16'h0000, 0, 0, 1'b0);
    send_event(OP_CHUNK_REQ, (stim_ver < 0) ? 0 : stim_ver, stim_class, 0, 0, 1'b0);
    send_event(OP_MANIFEST_DATA, 999, 16'h0000, 0, 12, 1'b0);
    stim_ver   = 999;
    stim_count = 12;
    fill_idx   = 0;
    run_random(100, 40);
    drain();
    repeat (20) @(posedge clk);

    $display("Run covered %0d event beats and %0d result beats over plain, cascade and",
             events_seen, results_seen);
    $display("gateway settings, chunk counts from zero to the full bitmap, versions up to 999.");
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
